>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the console writer.
// Each checker that includes this file must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define TXC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define TXC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/txc_pkg.sv
// Shared types and constants of the text-mode console writer.
// No dependencies; every module file of the block imports it.
`default_nettype none

package txc_pkg;

  localparam int ScreenWidthDef  = 80;
  localparam int ScreenHeightDef = 25;

  localparam int CellW    = 16;
  localparam int CharW    = 8;
  localparam int ColorW   = 4;
  localparam int AttrW    = 2 * ColorW;
  localparam int RowPortW = 5;
  localparam int ColPortW = 7;
  localparam int OpW      = 2;
  localparam int CfgIdxW  = 2;
  localparam int CmdQueueDepth = 2;

  localparam logic [CharW-1:0]  NewlineCode = 8'd10;
  localparam logic [CharW-1:0]  SpaceCode   = 8'd32;
  localparam logic [ColorW-1:0] ResetFg     = 4'hF;
  localparam logic [ColorW-1:0] ResetBg     = 4'h0;
  localparam logic [CellW-1:0]  InitCell    = {ResetBg, ResetFg, SpaceCode};

  // Operation codes on the input channel
  localparam logic [OpW-1:0] OpPut   = 2'd0;
  localparam logic [OpW-1:0] OpClear = 2'd1;
  localparam logic [OpW-1:0] OpRead  = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFg = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBg = 2'd1;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_CLEAR,
    CMD_READ,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e                kind;
    logic [CharW-1:0]    ch;
    logic [RowPortW-1:0] row;
    logic [ColPortW-1:0] col;
    logic                rd_ok;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/text_mode_console_writer_top.sv
// Top level of the text-mode console writer: color registers, front end,
// command queue and back end. Depends on txc_pkg, txc_front, txc_queue, txc_back.
`default_nettype none

// Text console of SCREEN_WIDTH x SCREEN_HEIGHT cells of 16 bits ({bg, fg, char}) with a
// cursor; every item gives one result carrying the cursor after the item. After reset the
// block walks the whole cell store once to blank it and holds in_stall_o high meanwhile.
// An item then passes through the command queue; put character, newline and unused codes
// finish in the back end's idle state, a read goes on through a read state (registered
// store read). A scroll rewrites only one row, since rows form a ring in the store; a clear
// rewrites every cell. Both sweeps go through the single write port of the store. Results
// wait in an output register while the queue keeps taking items until it is full.
module text_mode_console_writer_top import txc_pkg::*; #(
  parameter int SCREEN_WIDTH  = ScreenWidthDef,
  parameter int SCREEN_HEIGHT = ScreenHeightDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ColorW-1:0]   cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [OpW-1:0]      operation_i,
  input  wire logic [CharW-1:0]    character_i,
  input  wire logic [RowPortW-1:0] read_row_i,
  input  wire logic [ColPortW-1:0] read_column_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [CellW-1:0]         cell_value_o,
  output logic [RowPortW-1:0]      cursor_row_o,
  output logic [ColPortW-1:0]      cursor_column_o,
  output logic                     scrolled_o
);

  logic [ColorW-1:0] fg_q;
  logic [ColorW-1:0] bg_q;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic              push;
  logic              init_busy;
  cmd_t              front_cmd;
  cmd_t              back_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= ResetFg;
      bg_q <= ResetBg;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgFg:   fg_q <= cfg_wdata_i;
        CfgBg:   bg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  txc_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .character_i  (character_i),
    .read_row_i   (read_row_i),
    .read_column_i(read_column_i),
    .q_full_i     (q_full),
    .init_busy_i  (init_busy),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  txc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .cmd_o  (back_cmd)
  );

  txc_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_i          (back_cmd),
    .cmd_pop_o      (q_pop),
    .attr_i         ({bg_q, fg_q}),
    .init_busy_o    (init_busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cell_value_o   (cell_value_o),
    .cursor_row_o   (cursor_row_o),
    .cursor_column_o(cursor_column_o),
    .scrolled_o     (scrolled_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/txc_front.sv
// Front end of the console writer: input handshake and decode into commands.
// Depends on txc_pkg.
`default_nettype none

module txc_front import txc_pkg::*; #(
  parameter int SCREEN_WIDTH  = ScreenWidthDef,
  parameter int SCREEN_HEIGHT = ScreenHeightDef
) (
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [OpW-1:0]      operation_i,
  input  wire logic [CharW-1:0]    character_i,
  input  wire logic [RowPortW-1:0] read_row_i,
  input  wire logic [ColPortW-1:0] read_column_i,
  input  wire logic                q_full_i,
  input  wire logic                init_busy_i,
  output logic                     push_o,
  output cmd_t                     cmd_o
);

  assign in_stall_o = q_full_i | init_busy_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  always_comb begin
    cmd_o.ch    = character_i;
    cmd_o.row   = read_row_i;
    cmd_o.col   = read_column_i;
    cmd_o.rd_ok = (32'(read_row_i) < 32'(SCREEN_HEIGHT)) &&
                  (32'(read_column_i) < 32'(SCREEN_WIDTH));
    unique case (operation_i)
      OpPut:   cmd_o.kind = (character_i == NewlineCode) ? CMD_NEWLINE : CMD_PUT;
      OpClear: cmd_o.kind = CMD_CLEAR;
      OpRead:  cmd_o.kind = CMD_READ;
      default: cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/txc_queue.sv
// Short command queue between the front end and the back end.
// Depends on txc_pkg.
`default_nettype none

module txc_queue import txc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  output logic      valid_o,
  input  wire logic pop_i,
  output cmd_t      cmd_o
);

  localparam int PtrW = (CmdQueueDepth > 1) ? $clog2(CmdQueueDepth) : 1;
  localparam int CntW = $clog2(CmdQueueDepth + 1);

  cmd_t            ent_q [CmdQueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(CmdQueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CntW'(CmdQueueDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/txc_back.sv
// Back end of the console writer: cursor, cell store, scroll and clear sweeps,
// and the output register. Depends on txc_pkg.
`default_nettype none

module txc_back import txc_pkg::*; #(
  parameter int SCREEN_WIDTH  = ScreenWidthDef,
  parameter int SCREEN_HEIGHT = ScreenHeightDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cmd_valid_i,
  input  wire cmd_t                cmd_i,
  output logic                     cmd_pop_o,
  input  wire logic [AttrW-1:0]    attr_i,
  output logic                     init_busy_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [CellW-1:0]         cell_value_o,
  output logic [RowPortW-1:0]      cursor_row_o,
  output logic [ColPortW-1:0]      cursor_column_o,
  output logic                     scrolled_o
);

  localparam int Depth   = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AddrW   = $clog2(Depth);
  localparam int RowW    = $clog2(SCREEN_HEIGHT);
  localparam int ColW    = $clog2(SCREEN_WIDTH);
  localparam int RowSumW = RowW + 1;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_READ
  } state_e;

  state_e              state_q, state_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [ColW-1:0]     col_q, col_d;
  logic [RowW-1:0]     top_q, top_d;
  logic [AddrW-1:0]    fill_addr_q, fill_addr_d;
  logic [AddrW-1:0]    fill_last_q, fill_last_d;
  logic [CellW-1:0]    fill_data_q, fill_data_d;
  logic                rd_ok_q, rd_ok_d;
  logic                out_valid_q, out_valid_d;
  logic [CellW-1:0]    out_cell_q, out_cell_d;
  logic [RowPortW-1:0] out_row_q, out_row_d;
  logic [ColPortW-1:0] out_col_q, out_col_d;
  logic                out_scr_q, out_scr_d;

  logic [CellW-1:0]    mem_q [Depth];
  logic [CellW-1:0]    rdata_q;
  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr;
  logic [CellW-1:0]    mem_wdata;
  logic [AddrW-1:0]    mem_raddr;

  logic                take;
  logic                line_adv;
  logic                at_eol;
  logic                at_last;
  logic [AddrW-1:0]    cur_addr;
  logic [AddrW-1:0]    top_base;
  logic [CellW-1:0]    blank;

  // Logical row to physical row: rows live in a ring that starts at top_q.
  function automatic logic [RowW-1:0] phys_row(input logic [RowW-1:0] lrow,
                                               input logic [RowW-1:0] top);
    logic [RowSumW-1:0] sum;
    sum = {1'b0, lrow} + {1'b0, top};
    if (sum >= RowSumW'(SCREEN_HEIGHT)) begin
      sum = sum - RowSumW'(SCREEN_HEIGHT);
    end
    return sum[RowW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] cell_addr(input logic [RowW-1:0] prow,
                                                 input logic [ColW-1:0] col);
    return AddrW'(prow) * AddrW'(SCREEN_WIDTH) + AddrW'(col);
  endfunction

  assign at_eol    = (col_q == ColW'(SCREEN_WIDTH - 1));
  assign at_last   = (row_q == RowW'(SCREEN_HEIGHT - 1));
  assign cur_addr  = cell_addr(phys_row(row_q, top_q), col_q);
  assign top_base  = cell_addr(top_q, '0);
  assign blank     = {attr_i, SpaceCode};
  assign mem_raddr = cell_addr(phys_row(RowW'(cmd_i.row), top_q), ColW'(cmd_i.col));
  assign take      = (state_q == ST_IDLE) && cmd_valid_i && (!out_valid_q || !out_stall_i);

  assign cmd_pop_o       = take;
  assign init_busy_o     = (state_q == ST_INIT);
  assign out_valid_o     = out_valid_q;
  assign cell_value_o    = out_cell_q;
  assign cursor_row_o    = out_row_q;
  assign cursor_column_o = out_col_q;
  assign scrolled_o      = out_scr_q;

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    top_d       = top_q;
    fill_addr_d = fill_addr_q;
    fill_last_d = fill_last_q;
    fill_data_d = fill_data_q;
    rd_ok_d     = rd_ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_cell_d  = out_cell_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_scr_d   = out_scr_q;
    mem_we      = 1'b0;
    mem_waddr   = fill_addr_q;
    mem_wdata   = fill_data_q;
    line_adv    = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = InitCell;
        if (fill_addr_q == AddrW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end else begin
          fill_addr_d = fill_addr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (take) begin
          out_valid_d = 1'b1;
          out_cell_d  = '0;
          out_scr_d   = 1'b0;
          unique case (cmd_i.kind)
            CMD_PUT: begin
              mem_we    = 1'b1;
              mem_waddr = cur_addr;
              mem_wdata = {attr_i, cmd_i.ch};
              if (at_eol) begin
                line_adv = 1'b1;
              end else begin
                col_d = col_q + 1'b1;
              end
            end
            CMD_NEWLINE: line_adv = 1'b1;
            CMD_CLEAR: begin
              fill_addr_d = '0;
              fill_last_d = AddrW'(Depth - 1);
              fill_data_d = blank;
              state_d     = ST_FILL;
            end
            CMD_READ: begin
              // hold the result until the store returns the cell
              out_valid_d = 1'b0;
              rd_ok_d     = cmd_i.rd_ok;
              state_d     = ST_READ;
            end
            CMD_NOP: ;
          endcase

          if (line_adv) begin
            col_d = '0;
            if (at_last) begin
              // drop the top row: blank it and make it the new last row
              fill_addr_d = top_base;
              fill_last_d = top_base + AddrW'(SCREEN_WIDTH - 1);
              fill_data_d = blank;
              top_d       = (top_q == RowW'(SCREEN_HEIGHT - 1)) ? '0 : top_q + 1'b1;
              out_scr_d   = 1'b1;
              state_d     = ST_FILL;
            end else begin
              row_d = row_q + 1'b1;
            end
          end

          out_row_d = RowPortW'(row_d);
          out_col_d = ColPortW'(col_d);
        end
      end

      ST_FILL: begin
        mem_we = 1'b1;
        if (fill_addr_q == fill_last_q) begin
          state_d = ST_IDLE;
        end else begin
          fill_addr_d = fill_addr_q + 1'b1;
        end
      end

      ST_READ: begin
        out_valid_d = 1'b1;
        out_cell_d  = rd_ok_q ? rdata_q : '0;
        out_row_d   = RowPortW'(row_q);
        out_col_d   = ColPortW'(col_q);
        out_scr_d   = 1'b0;
        state_d     = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      row_q       <= '0;
      col_q       <= '0;
      top_q       <= '0;
      fill_addr_q <= '0;
      fill_last_q <= '0;
      fill_data_q <= InitCell;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_cell_q  <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_scr_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      top_q       <= top_d;
      fill_addr_q <= fill_addr_d;
      fill_last_q <= fill_last_d;
      fill_data_q <= fill_data_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
      out_cell_q  <= out_cell_d;
      out_row_q   <= out_row_d;
      out_col_q   <= out_col_d;
      out_scr_q   <= out_scr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/txc_checker.sv
// Port-level checks of the console writer's result channel, bound to the top level.
// Depends on txc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module txc_checker import txc_pkg::*; #(
  parameter int SCREEN_WIDTH  = ScreenWidthDef,
  parameter int SCREEN_HEIGHT = ScreenHeightDef
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_i,
  input wire logic                out_stall_i,
  input wire logic [CellW-1:0]    cell_value_i,
  input wire logic [RowPortW-1:0] cursor_row_i,
  input wire logic [ColPortW-1:0] cursor_column_i,
  input wire logic                scrolled_i
);

  `TXC_ASSERT(a_out_hold, out_valid_i && out_stall_i |=> out_valid_i && $stable(cell_value_i) && $stable(cursor_row_i) && $stable(cursor_column_i) && $stable(scrolled_i), "stalled result changed")
  `TXC_ASSERT(a_cursor_range, out_valid_i |-> (32'(cursor_row_i) < 32'(SCREEN_HEIGHT)) && (32'(cursor_column_i) < 32'(SCREEN_WIDTH)), "cursor outside the screen")
  `TXC_ASSERT(a_scroll_cursor, out_valid_i && scrolled_i |-> cursor_row_i == RowPortW'(SCREEN_HEIGHT - 1) && cursor_column_i == '0, "scroll left cursor off the last row start")
  `TXC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_i, "result shown during reset")

endmodule

bind text_mode_console_writer_top txc_checker #(
  .SCREEN_WIDTH (SCREEN_WIDTH),
  .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_txc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .cell_value_i   (cell_value_o),
  .cursor_row_i   (cursor_row_o),
  .cursor_column_i(cursor_column_o),
  .scrolled_i     (scrolled_o)
);

`default_nettype wire
